/* hdl/tets_pkg.sv */
// shared types and constants for the tx extra tag scanner
// used by tets_front, tets_queue, tets_back and tx_extra_tag_scanner_core
package tets_pkg;

  localparam int FIELD_BYTES = 32;
  localparam int MM_MIN_SIZE = 33;
  localparam int NONCE_SPAN  = 32 + 1 + 1;
  localparam int NUM_RESULTS = 13;
  localparam int AFTER_W     = 10;
  // remaining count of a judged byte: bytes_after plus up to three
  localparam int REM_W       = AFTER_W + 1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int EMIT_W      = $clog2(NUM_RESULTS);

  // configuration register indexes
  localparam logic [1:0] CFG_PUBKEY_TAG     = 2'd0;
  localparam logic [1:0] CFG_NONCE_TAG      = 2'd1;
  localparam logic [1:0] CFG_PAYMENT_ID_TAG = 2'd2;
  localparam logic [1:0] CFG_MERGE_MINE_TAG = 2'd3;

  // result field kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_PID   = 2'd1;
  localparam logic [1:0] KIND_ROOT  = 2'd2;
  localparam logic [1:0] KIND_DEPTH = 2'd3;

  typedef struct packed {
    logic [7:0] pubkey_tag;
    logic [7:0] nonce_tag;
    logic [7:0] payment_id_tag;
    logic [7:0] merge_mining_tag;
  } cfg_t;

  // one operation for the back end: judge a byte or emit the run's results
  typedef struct packed {
    logic             is_emit;
    logic [7:0]       b;
    logic [7:0]       n1;
    logic [7:0]       n2;
    logic [REM_W-1:0] rem;
  } op_t;

  typedef struct packed {
    logic [1:0]  field_kind;
    logic [1:0]  word_index;
    logic [63:0] word_data;
    logic        found;
    logic        last_word;
  } result_t;

endpackage

/* hdl/tx_extra_tag_scanner_core.sv */
// Scans a transaction extra field one byte per item and reports the first
// public key, payment ID and merged-mining root/depth as 13 result items at
// the end of each run. Bytes are taken one per cycle while in_full is low; a
// byte is matched two bytes later, once its lookahead window is full. The
// last byte of a run (bytes_after of zero) holds the input full while the
// front end drains the window and then an emit op into the op queue. The
// back end then plays out the captured fields, one result item at a time,
// through the output register; bytes of the next run keep entering meanwhile
// until the four-entry op queue fills. Tag bytes must be set through the cfg_
// write port only while the block is idle; the block does not enforce this.
// depends on tets_pkg, tets_front, tets_queue and tets_back
module tx_extra_tag_scanner_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [7:0]                   cfg_wdata,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [7:0]                   in_byte_value,
  input  logic [tets_pkg::AFTER_W-1:0] in_bytes_after,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [1:0]                   out_field_kind,
  output logic [1:0]                   out_word_index,
  output logic [63:0]                  out_word_data,
  output logic                         out_found,
  output logic                         out_last_word
);
  import tets_pkg::*;

  cfg_t cfg_r;
  logic q_push;
  op_t  q_op;
  logic q_full;
  logic q_pop;
  op_t  q_head;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pubkey_tag       <= 8'd1;
      cfg_r.nonce_tag        <= 8'd2;
      cfg_r.payment_id_tag   <= 8'd0;
      cfg_r.merge_mining_tag <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PUBKEY_TAG:     cfg_r.pubkey_tag       <= cfg_wdata;
        CFG_NONCE_TAG:      cfg_r.nonce_tag        <= cfg_wdata;
        CFG_PAYMENT_ID_TAG: cfg_r.payment_id_tag   <= cfg_wdata;
        CFG_MERGE_MINE_TAG: cfg_r.merge_mining_tag <= cfg_wdata;
      endcase
    end
  end

  tets_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte_value  (in_byte_value),
    .in_bytes_after (in_bytes_after),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (q_op)
  );

  tets_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .head_op (q_head),
    .empty   (q_empty)
  );

  tets_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .op_empty       (q_empty),
    .op             (q_head),
    .op_pop         (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_field_kind (out_field_kind),
    .out_word_index (out_word_index),
    .out_word_data  (out_word_data),
    .out_found      (out_found),
    .out_last_word  (out_last_word)
  );

endmodule

/* hdl/tets_front.sv */
// front end: takes bytes, keeps the two-byte lookahead window and issues
// judge and emit operations into the op queue; depends on tets_pkg
module tets_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_byte_value,
  input  logic [tets_pkg::AFTER_W-1:0]  in_bytes_after,
  input  logic                          q_full,
  output logic                          q_push,
  output tets_pkg::op_t                 q_op
);
  import tets_pkg::*;

  logic [7:0] win0_r, win0_nxt;
  logic [7:0] win1_r, win1_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       flush_r, flush_nxt;
  logic [7:0] fq0_r, fq0_nxt;
  logic [7:0] fq1_r, fq1_nxt;
  logic [7:0] fq2_r, fq2_nxt;
  logic [1:0] fn_r, fn_nxt;
  logic       accept;

  assign in_full = flush_r || q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    win0_nxt  = win0_r;
    win1_nxt  = win1_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    fq0_nxt   = fq0_r;
    fq1_nxt   = fq1_r;
    fq2_nxt   = fq2_r;
    fn_nxt    = fn_r;
    q_push    = 1'b0;
    q_op      = '0;
    if (flush_r) begin
      // drain the held bytes one per cycle while the queue is not full, then the emit
      if (!q_full) begin
        q_push = 1'b1;
        if (fn_r != 2'd0) begin
          q_op.b   = fq0_r;
          q_op.n1  = fq1_r;
          q_op.n2  = fq2_r;
          q_op.rem = REM_W'(fn_r);
          fq0_nxt  = fq1_r;
          fq1_nxt  = fq2_r;
          fq2_nxt  = 8'd0;
          fn_nxt   = fn_r - 2'd1;
        end else begin
          q_op.is_emit = 1'b1;
          flush_nxt    = 1'b0;
        end
      end
    end else if (accept) begin
      if (in_bytes_after != '0) begin
        case (fill_r)
          2'd0: begin
            win0_nxt = in_byte_value;
            fill_nxt = 2'd1;
          end
          2'd1: begin
            win1_nxt = in_byte_value;
            fill_nxt = 2'd2;
          end
          default: begin
            q_push   = 1'b1;
            q_op.b   = win0_r;
            q_op.n1  = win1_r;
            q_op.n2  = in_byte_value;
            q_op.rem = REM_W'(in_bytes_after) + REM_W'(3);
            win0_nxt = win1_r;
            win1_nxt = in_byte_value;
          end
        endcase
      end else begin
        // last byte: hold window plus this byte, absent places read zero
        case (fill_r)
          2'd0: begin
            fq0_nxt = in_byte_value;
            fq1_nxt = 8'd0;
            fq2_nxt = 8'd0;
          end
          2'd1: begin
            fq0_nxt = win0_r;
            fq1_nxt = in_byte_value;
            fq2_nxt = 8'd0;
          end
          default: begin
            fq0_nxt = win0_r;
            fq1_nxt = win1_r;
            fq2_nxt = in_byte_value;
          end
        endcase
        fn_nxt    = (fill_r == 2'd0) ? 2'd1 : ((fill_r == 2'd1) ? 2'd2 : 2'd3);
        flush_nxt = 1'b1;
        fill_nxt  = 2'd0;
        win0_nxt  = 8'd0;
        win1_nxt  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r  <= 8'd0;
      win1_r  <= 8'd0;
      fill_r  <= 2'd0;
      flush_r <= 1'b0;
      fn_r    <= 2'd0;
    end else begin
      win0_r  <= win0_nxt;
      win1_r  <= win1_nxt;
      fill_r  <= fill_nxt;
      flush_r <= flush_nxt;
      fn_r    <= fn_nxt;
    end
    fq0_r <= fq0_nxt;
    fq1_r <= fq1_nxt;
    fq2_r <= fq2_nxt;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3) else $error("window fill out of range");

endmodule

/* hdl/tets_queue.sv */
// short op queue between front and back end
// depends on tets_pkg for op_t and the queue depth
module tets_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tets_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output tets_pkg::op_t head_op,
  output logic          empty
);
  import tets_pkg::*;

  op_t               slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head_op = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("op pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("op popped from empty queue");

endmodule

/* hdl/tets_back.sv */
// back end: runs the tag matching state machine on queued ops, holds the
// captured fields and plays out the 13 result words; depends on tets_pkg
module tets_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tets_pkg::cfg_t cfg,
  input  logic          op_empty,
  input  tets_pkg::op_t op,
  output logic          op_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [1:0]    out_field_kind,
  output logic [1:0]    out_word_index,
  output logic [63:0]   out_word_data,
  output logic          out_found,
  output logic          out_last_word
);
  import tets_pkg::*;

  typedef enum logic {B_RUN, B_EMIT} bstate_t;
  typedef enum logic [2:0] {
    M_SCAN, M_CAP_KEY, M_SKIP_PID, M_CAP_PID, M_SKIP_ROOT, M_CAP_ROOT, M_TAIL
  } mode_t;

  bstate_t                 state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic [1:0]              skip_r, skip_nxt;
  logic [4:0]              cap_r, cap_nxt;
  logic [7:0]              tail_r, tail_nxt;
  logic [2:0]              seen_r, seen_nxt;
  logic [2:0][3:0][63:0]   store_r, store_nxt;
  logic [7:0]              depth_r, depth_nxt;
  logic [EMIT_W-1:0]       cnt_r, cnt_nxt;
  result_t                 out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic       load_ok;
  logic [1:0] cap_sel;
  logic [1:0] skip_dec;
  logic [7:0] tail_dec;
  logic [1:0] emit_kind;
  result_t    res;

  assign load_ok   = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_field_kind = out_r.field_kind;
  assign out_word_index = out_r.word_index;
  assign out_word_data  = out_r.word_data;
  assign out_found      = out_r.found;
  assign out_last_word  = out_r.last_word;

  assign skip_dec  = (skip_r == 2'd0) ? 2'd0 : skip_r - 2'd1;
  assign tail_dec  = (tail_r == 8'd0) ? 8'd0 : tail_r - 8'd1;
  assign emit_kind = cnt_r[3:2];

  always_comb begin
    case (mode_r)
      M_CAP_KEY: cap_sel = KIND_KEY;
      M_CAP_PID: cap_sel = KIND_PID;
      default:   cap_sel = KIND_ROOT;
    endcase
  end

  // result word at the emit counter; unfound fields read as zero
  always_comb begin
    res = '0;
    res.field_kind = emit_kind;
    res.word_index = cnt_r[1:0];
    res.last_word  = (cnt_r == EMIT_W'(NUM_RESULTS - 1));
    case (emit_kind)
      KIND_KEY: begin
        res.found     = seen_r[0];
        res.word_data = seen_r[0] ? store_r[0][cnt_r[1:0]] : 64'd0;
      end
      KIND_PID: begin
        res.found     = seen_r[1];
        res.word_data = seen_r[1] ? store_r[1][cnt_r[1:0]] : 64'd0;
      end
      KIND_ROOT: begin
        res.found     = seen_r[2];
        res.word_data = seen_r[2] ? store_r[2][cnt_r[1:0]] : 64'd0;
      end
      default: begin
        res.word_index = 2'd0;
        res.found      = seen_r[2];
        res.word_data  = seen_r[2] ? {56'd0, depth_r} : 64'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    skip_nxt      = skip_r;
    cap_nxt       = cap_r;
    tail_nxt      = tail_r;
    seen_nxt      = seen_r;
    store_nxt     = store_r;
    depth_nxt     = depth_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    op_pop        = 1'b0;
    unique case (state_r)
      B_RUN: begin
        if (!op_empty) begin
          op_pop = 1'b1;
          if (op.is_emit) begin
            state_nxt = B_EMIT;
            cnt_nxt   = '0;
          end else begin
            unique case (mode_r) inside
              M_SCAN: begin
                if (seen_r != 3'b111) begin
                  if (op.b == cfg.pubkey_tag && op.rem > REM_W'(FIELD_BYTES)
                      && !seen_r[0]) begin
                    seen_nxt[0] = 1'b1;
                    mode_nxt    = M_CAP_KEY;
                    cap_nxt     = 5'd0;
                  end else if (op.b == cfg.nonce_tag && op.rem > REM_W'(NONCE_SPAN)
                               && op.n2 == cfg.payment_id_tag && !seen_r[1]) begin
                    seen_nxt[1] = 1'b1;
                    mode_nxt    = M_SKIP_PID;
                    skip_nxt    = 2'd2;
                  end else if (op.b == cfg.merge_mining_tag && !seen_r[2]
                               && op.rem > REM_W'(1)
                               && op.n1 >= 8'(MM_MIN_SIZE)
                               && op.rem > REM_W'(op.n1) + REM_W'(1)) begin
                    seen_nxt[2] = 1'b1;
                    depth_nxt   = op.n2;
                    tail_nxt    = op.n1 - 8'(MM_MIN_SIZE);
                    mode_nxt    = M_SKIP_ROOT;
                    skip_nxt    = 2'd2;
                  end
                end
              end
              M_SKIP_PID, M_SKIP_ROOT: begin
                skip_nxt = skip_dec;
                if (skip_dec == 2'd0) begin
                  mode_nxt = (mode_r == M_SKIP_PID) ? M_CAP_PID : M_CAP_ROOT;
                  cap_nxt  = 5'd0;
                end
              end
              M_CAP_KEY, M_CAP_PID, M_CAP_ROOT: begin
                store_nxt[cap_sel][cap_r[4:3]][{cap_r[2:0], 3'b000} +: 8] = op.b;
                if (cap_r >= 5'(FIELD_BYTES - 1)) begin
                  cap_nxt  = 5'd0;
                  mode_nxt = (mode_r == M_CAP_ROOT && tail_r != 8'd0) ? M_TAIL : M_SCAN;
                end else begin
                  cap_nxt = cap_r + 5'd1;
                end
              end
              M_TAIL: begin
                tail_nxt = tail_dec;
                if (tail_dec == 8'd0) begin
                  mode_nxt = M_SCAN;
                end
              end
              default: mode_nxt = M_SCAN;
            endcase
          end
        end
      end
      B_EMIT: begin
        if (load_ok) begin
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          if (cnt_r == EMIT_W'(NUM_RESULTS - 1)) begin
            // run done: clear the scan state and captured fields for the next extra
            state_nxt = B_RUN;
            mode_nxt  = M_SCAN;
            skip_nxt  = 2'd0;
            cap_nxt   = 5'd0;
            tail_nxt  = 8'd0;
            seen_nxt  = 3'b000;
            store_nxt = '0;
            depth_nxt = 8'd0;
          end else begin
            cnt_nxt = cnt_r + EMIT_W'(1);
          end
        end
      end
      default: state_nxt = B_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_RUN;
      mode_r      <= M_SCAN;
      skip_r      <= 2'd0;
      cap_r       <= 5'd0;
      tail_r      <= 8'd0;
      seen_r      <= 3'b000;
      store_r     <= '0;
      depth_r     <= 8'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      skip_r      <= skip_nxt;
      cap_r       <= cap_nxt;
      tail_r      <= tail_nxt;
      seen_r      <= seen_nxt;
      store_r     <= store_nxt;
      depth_r     <= depth_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> cnt_r <= EMIT_W'(NUM_RESULTS - 1))
    else $error("emit counter past last result");

  a_last_is_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_word |-> out_r.field_kind == KIND_DEPTH)
    else $error("last item is not the depth word");

endmodule
